/* sv/cge_pkg.sv */
package cge_pkg;

    localparam int NUM_KEYS    = 4;
    localparam int DUR_W       = 16;
    localparam int CH_W        = 8;
    localparam int NUM_CH      = 4;
    localparam int COL_W       = NUM_CH * CH_W;
    localparam int NUM_W       = DUR_W + CH_W;
    localparam int KEY_W       = 48;
    localparam int REG_W       = 64;
    localparam int ADDR_W      = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_STEPS   = CH_W;

    localparam logic [2:0] REG_KEY_COUNT = 3'd0;
    localparam logic [2:0] REG_KEY_FIRST = 3'd1;
    localparam logic [2:0] REG_KEY_LAST  = 3'd4;

    localparam logic [2:0]       KEY_COUNT_RESET = 3'd1;
    localparam logic [KEY_W-1:0] KEY0_RESET      = 48'h0200_FFFF_FFFF;

    typedef logic [NUM_KEYS-1:0][KEY_W-1:0] t_key_words;

    // one blend job: colour = floor((c0*w0 + c1*w1) / d), w0 + w1 = d
    typedef struct packed {
        logic             past_end;
        logic [COL_W-1:0] c0;
        logic [COL_W-1:0] c1;
        logic [DUR_W-1:0] w0;
        logic [DUR_W-1:0] w1;
        logic [DUR_W-1:0] d;
    } t_job;

endpackage

/* sv/colour_gradient_evaluator.sv */
// Colour gradient evaluator: an age written with start (taken while busy is low)
// yields one RGBA colour on o_red..o_alpha with o_past_end, shown for exactly one
// cycle under o_valid; the receiver cannot stall, so it must take every strobe.
// Each item passes through the back end as one queue pop, one multiply state and
// eight restoring divide steps run in parallel in the four channel lanes; the
// back end pops no new item until the divide of the one before it is done.
// A two-entry queue between classification and interpolation lets two more items
// be taken while one is worked on; busy is high only while that queue is full.
// Key registers lie at byte addresses 8*i on a 64-bit APB port; the user must write
// them only while no item is in flight, as the block itself does not enforce it.
module colour_gradient_evaluator import cge_pkg::*; #(
    parameter int MAX_KEYS  = 4,
    parameter int TIME_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [DUR_W-1:0]  i_alive_time,
    output logic              o_valid,
    output logic [CH_W-1:0]   o_red,
    output logic [CH_W-1:0]   o_green,
    output logic [CH_W-1:0]   o_blue,
    output logic [CH_W-1:0]   o_alpha,
    output logic              o_past_end,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    output logic [REG_W-1:0]  prdata,
    output logic              pready
);

    logic [2:0]   r_key_count;
    t_key_words   r_key_words;
    logic [2:0]   reg_idx;
    logic         cfg_wr;
    t_job         front_job;
    t_job         head_job;
    logic         push;
    logic         pop;
    logic         full;
    logic         empty;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= KEY_COUNT_RESET;
            r_key_words <= {{((NUM_KEYS - 1) * KEY_W){1'b0}}, KEY0_RESET};
        end else if (cfg_wr) begin
            if (reg_idx == REG_KEY_COUNT) begin
                r_key_count <= pwdata[2:0];
            end
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (reg_idx == REG_KEY_FIRST + 3'(k)) begin
                    r_key_words[k] <= pwdata[KEY_W-1:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_KEY_COUNT) begin
            prdata = REG_W'(r_key_count);
        end else if (reg_idx <= REG_KEY_LAST) begin
            prdata = REG_W'(r_key_words[2'(reg_idx - REG_KEY_FIRST)]);
        end
    end

    assign busy = full;
    assign push = start && !full;

    cge_front #(
        .MAX_KEYS  (MAX_KEYS),
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_alive_time (i_alive_time),
        .i_key_count  (r_key_count),
        .i_key_words  (r_key_words),
        .o_job        (front_job)
    );

    cge_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    cge_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_job      (head_job),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_red      (o_red),
        .o_green    (o_green),
        .o_blue     (o_blue),
        .o_alpha    (o_alpha),
        .o_past_end (o_past_end)
    );

endmodule

/* sv/cge_front.sv */
module cge_front import cge_pkg::*; #(
    parameter int MAX_KEYS  = 4,
    parameter int TIME_BITS = 16
) (
    input  logic [DUR_W-1:0] i_alive_time,
    input  logic [2:0]       i_key_count,
    input  t_key_words       i_key_words,
    output t_job             o_job
);

    localparam int TW    = (TIME_BITS < DUR_W) ? TIME_BITS : DUR_W;
    localparam int LIM   = (MAX_KEYS < NUM_KEYS) ? MAX_KEYS : NUM_KEYS;
    localparam int SUM_W = DUR_W + 2;
    localparam logic [DUR_W-1:0] TMASK = {DUR_W{1'b1}} >> (DUR_W - TW);
    localparam logic [2:0] LIM3 = 3'(LIM);

    logic [DUR_W-1:0] t;
    logic [DUR_W-1:0] dur [NUM_KEYS];
    logic [COL_W-1:0] col [NUM_KEYS];
    logic [SUM_W-1:0] sum [NUM_KEYS];
    logic [2:0]       n;
    logic             hit;
    logic [COL_W-1:0] seg_c0;
    logic [COL_W-1:0] seg_c1;
    logic [DUR_W-1:0] seg_d;
    logic [DUR_W-1:0] seg_u;

    always_comb begin
        t = i_alive_time & TMASK;
        for (int k = 0; k < NUM_KEYS; k++) begin
            dur[k] = i_key_words[k][32 +: DUR_W] & TMASK;
            col[k] = i_key_words[k][COL_W-1:0];
        end

        if (i_key_count == 3'd0) begin
            n = 3'd1;
        end else if (i_key_count > LIM3) begin
            n = LIM3;
        end else begin
            n = i_key_count;
        end

        sum[0] = '0;
        for (int j = 0; j < NUM_KEYS - 1; j++) begin
            sum[j+1] = sum[j] + SUM_W'(dur[j]);
        end

        // first segment whose end reaches the age wins, so scan downward
        hit    = 1'b0;
        seg_c0 = '0;
        seg_c1 = '0;
        seg_d  = '0;
        seg_u  = '0;
        for (int j = NUM_KEYS - 2; j >= 0; j--) begin
            if (((3'(j) + 3'd1) < n) && (sum[j+1] >= SUM_W'(t))) begin
                hit    = 1'b1;
                seg_c0 = col[j];
                seg_c1 = col[j+1];
                seg_d  = dur[j];
                seg_u  = DUR_W'(SUM_W'(t) - sum[j]);
            end
        end

        if ((n == 3'd1) || (t == '0)) begin
            o_job.past_end = 1'b0;
            o_job.c0       = col[0];
            o_job.c1       = col[0];
            o_job.w0       = DUR_W'(1);
            o_job.w1       = '0;
            o_job.d        = DUR_W'(1);
        end else if (!hit) begin
            o_job.past_end = 1'b1;
            o_job.c0       = '0;
            o_job.c1       = '0;
            o_job.w0       = DUR_W'(1);
            o_job.w1       = '0;
            o_job.d        = DUR_W'(1);
        end else begin
            o_job.past_end = 1'b0;
            o_job.c0       = seg_c0;
            o_job.c1       = seg_c1;
            o_job.w0       = seg_d - seg_u;
            o_job.w1       = seg_u;
            o_job.d        = seg_d;
        end
    end

endmodule

/* sv/cge_queue.sv */
module cge_queue import cge_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("transaction pushed into a full queue");

endmodule

/* sv/cge_back.sv */
module cge_back import cge_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  t_job            i_job,
    output logic            o_pop,
    output logic            o_valid,
    output logic [CH_W-1:0] o_red,
    output logic [CH_W-1:0] o_green,
    output logic [CH_W-1:0] o_blue,
    output logic [CH_W-1:0] o_alpha,
    output logic            o_past_end
);

    localparam int STEP_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_DIV  = 3'b100
    } t_state;

    t_state                           r_state;
    t_state                           n_state;
    logic                             r_valid;
    logic                             n_valid;
    logic [STEP_W-1:0]                r_step;
    t_job                             r_job;
    logic [NUM_CH-1:0][DUR_W-1:0]     r_rem;
    logic [NUM_CH-1:0][CH_W-1:0]      r_low;
    logic [NUM_CH-1:0][NUM_W-1:0]     num;
    logic [NUM_CH-1:0][DUR_W-1:0]     rem_next;
    logic [NUM_CH-1:0]                q_bit;
    logic [NUM_CH-1:0][DUR_W:0]       trial;

    assign o_pop = (r_state == ST_IDLE) && !i_empty;

    // per channel: c0*w0 + c1*w1, then one restoring divide step per cycle
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            num[ch] = NUM_W'(r_job.c0[COL_W-1-CH_W*ch -: CH_W]) * NUM_W'(r_job.w0)
                    + NUM_W'(r_job.c1[COL_W-1-CH_W*ch -: CH_W]) * NUM_W'(r_job.w1);
            trial[ch] = {r_rem[ch], r_low[ch][CH_W-1]};
            q_bit[ch] = (trial[ch] >= {1'b0, r_job.d});
            rem_next[ch] = q_bit[ch] ? DUR_W'(trial[ch] - {1'b0, r_job.d})
                                     : trial[ch][DUR_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_IDLE;
                    n_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == ST_MUL) begin
            r_step <= '0;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                // quotient fits in 8 bits, so the upper part is already below d
                r_rem[ch] <= num[ch][NUM_W-1:CH_W];
                r_low[ch] <= num[ch][CH_W-1:0];
            end
        end else if (r_state == ST_DIV) begin
            r_step <= r_step + 1'b1;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_rem[ch] <= rem_next[ch];
                r_low[ch] <= {r_low[ch][CH_W-2:0], q_bit[ch]};
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_red      = r_low[0];
    assign o_green    = r_low[1];
    assign o_blue     = r_low[2];
    assign o_alpha    = r_low[3];
    assign o_past_end = r_job.past_end;

    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held longer than one cycle");

    a_after_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state == ST_DIV))
        else $error("result strobe without a finished divide");

    a_past_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_job.past_end) |->
            (r_low[0] == '0 && r_low[1] == '0 && r_low[2] == '0 && r_low[3] == '0))
        else $error("past end result is not transparent black");

endmodule

/* tb/tb_colour_gradient_evaluator.sv */
`timescale 1ns / 100ps

module tb_colour_gradient_evaluator;
    import cge_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_AGES  = 50;
    localparam int NUM_PHASES  = 8;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            past_end;
    } t_colour;

    // keeps a copy of the key table and the colours still owed by the block
    class colour_check;
        logic [2:0]       key_count;
        logic [KEY_W-1:0] key_words [NUM_KEYS];
        t_colour          owed_colours [$];
        int               errors;

        function new();
            key_count = KEY_COUNT_RESET;
            key_words[0] = KEY0_RESET;
            for (int k = 1; k < NUM_KEYS; k++) begin
                key_words[k] = '0;
            end
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [REG_W-1:0] data);
            if (idx == REG_KEY_COUNT) begin
                key_count = data[2:0];
            end else if (idx <= REG_KEY_LAST) begin
                key_words[idx - REG_KEY_FIRST] = data[KEY_W-1:0];
            end
        endfunction

        function int used_keys();
            int n;
            n = key_count;
            if (n == 0) n = 1;
            if (n > NUM_KEYS) n = NUM_KEYS;
            return n;
        endfunction

        // end time of the first j segments
        function longint seg_end(int j);
            longint sum;
            sum = 0;
            for (int k = 0; k < j && k < NUM_KEYS; k++) begin
                sum += key_words[k][47:32];
            end
            return sum;
        endfunction

        function t_colour blend_colour(logic [DUR_W-1:0] age);
            t_colour         c;
            logic [CH_W-1:0] lane [NUM_CH];
            longint          t, total, seg_start, d, u, c0, c1, num;
            int              n, idx, k0;
            c = '0;
            t = age;
            n = used_keys();
            if (n == 1 || t == 0) begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    lane[ch] = key_words[0][31 - 8*ch -: 8];
                end
            end else begin
                idx = 0;
                total = 0;
                seg_start = 0;
                // zero-length segments fall through here
                while (total < t && idx < n) begin
                    seg_start = total;
                    total += key_words[idx][47:32];
                    idx++;
                end
                if (idx >= n) begin
                    c.past_end = 1'b1;
                    return c;
                end
                k0 = idx - 1;
                d = key_words[k0][47:32];
                u = t - seg_start;
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    c0 = key_words[k0][31 - 8*ch -: 8];
                    c1 = key_words[k0 + 1][31 - 8*ch -: 8];
                    num = c0 * d + (c1 - c0) * u;
                    lane[ch] = CH_W'(num / d);
                end
            end
            c.red   = lane[0];
            c.green = lane[1];
            c.blue  = lane[2];
            c.alpha = lane[3];
            return c;
        endfunction

        function void take_age(logic [DUR_W-1:0] age);
            owed_colours.insert(owed_colours.size(), blend_colour(age));
        endfunction

        function void check_colour(t_colour got);
            t_colour want;
            if (owed_colours.size() == 0) begin
                $error("unexpected colour transaction: %p", got);
                errors++;
                return;
            end
            want = owed_colours.pop_front();
            if (got.red !== want.red) begin
                $error("red: expected %0d, got %0d", want.red, got.red);
                errors++;
            end
            if (got.green !== want.green) begin
                $error("green: expected %0d, got %0d", want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue) begin
                $error("blue: expected %0d, got %0d", want.blue, got.blue);
                errors++;
            end
            if (got.alpha !== want.alpha) begin
                $error("alpha: expected %0d, got %0d", want.alpha, got.alpha);
                errors++;
            end
            if (got.past_end !== want.past_end) begin
                $error("past_end: expected %0d, got %0d", want.past_end, got.past_end);
                errors++;
            end
        endfunction

        function int owed();
            return owed_colours.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [DUR_W-1:0]  i_alive_time;
    logic              o_valid;
    logic [CH_W-1:0]   o_red;
    logic [CH_W-1:0]   o_green;
    logic [CH_W-1:0]   o_blue;
    logic [CH_W-1:0]   o_alpha;
    logic              o_past_end;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [REG_W-1:0]  pwdata;
    logic [REG_W-1:0]  prdata;
    logic              pready;

    colour_check sb;
    int          stall_cycles = 0;

    colour_gradient_evaluator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_alive_time (i_alive_time),
        .o_valid      (o_valid),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha),
        .o_past_end   (o_past_end),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // monitor: results, accepted ages, register writes, and the watchdog
    always @(posedge i_clk) begin
        if (o_valid === 1'b1) begin
            sb.check_colour({o_red, o_green, o_blue, o_alpha, o_past_end});
        end
        if (start && busy === 1'b0) begin
            sb.take_age(i_alive_time);
        end
        if (psel && penable && pwrite && pready === 1'b1) begin
            sb.write_reg(paddr[5:3], pwdata);
        end
        if (o_valid === 1'b1 || (start && busy === 1'b0)
                || (psel && penable && pwrite && pready === 1'b1)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_colour_gradient_evaluator: FAIL");
            $finish;
        end
    end

    function automatic logic [REG_W-1:0] key_word(logic [15:0] dur, logic [31:0] rgba);
        return {16'h0, dur, rgba};
    endfunction

    task automatic reg_write(logic [2:0] idx, logic [REG_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_age(logic [DUR_W-1:0] age);
        @(negedge i_clk);
        start        <= 1'b1;
        i_alive_time <= age;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic pause_sender(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start        <= 1'b0;
            i_alive_time <= DUR_W'($urandom);
        end
    endtask

    // block must be empty before the key table changes
    task automatic drain();
        pause_sender(1);
        while (sb.owed() != 0) @(posedge i_clk);
    endtask

    task automatic random_setup();
        int               sel;
        logic [2:0]       count;
        logic [15:0]      dur;
        logic [31:0]      rgba;
        sel = $urandom_range(0, 9);
        if (sel == 0) count = 3'd0;
        else if (sel == 1) count = 3'($urandom_range(5, 7));
        else if (sel == 2) count = 3'd1;
        else count = 3'($urandom_range(2, 4));
        reg_write(REG_KEY_COUNT, REG_W'(count));
        for (int k = 0; k < NUM_KEYS; k++) begin
            sel = $urandom_range(0, 7);
            if (sel == 0) dur = 16'h0;
            else if (sel == 1) dur = 16'hFFFF;
            else if (sel == 2) dur = 16'($urandom);
            else dur = 16'($urandom_range(1, 1024));
            sel = $urandom_range(0, 7);
            if (sel == 0) rgba = 32'h0;
            else if (sel == 1) rgba = 32'hFFFF_FFFF;
            else rgba = $urandom;
            reg_write(REG_KEY_FIRST + 3'(k), key_word(dur, rgba));
        end
    endtask

    function automatic logic [DUR_W-1:0] pick_age();
        int     sel;
        longint a;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            a = ($urandom_range(0, 1) == 0) ? 0 : 16'hFFFF;
        end else if (sel == 1) begin
            a = 16'($urandom);
        end else if (sel < 4) begin
            // land on or next to a segment boundary
            a = sb.seg_end($urandom_range(1, NUM_KEYS)) + $urandom_range(0, 2) - 1;
        end else begin
            a = sb.seg_end(sb.used_keys() - 1) + 2;
            if (a > 16'hFFFF) a = 16'hFFFF;
            a = $urandom_range(0, int'(a));
        end
        if (a < 0) a = 0;
        if (a > 16'hFFFF) a = 16'hFFFF;
        return DUR_W'(a);
    endfunction

    initial begin
        sb = new();
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_alive_time = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset table: a single white key whatever the age
        send_age(16'h0000);
        send_age(16'hFFFF);
        send_age(16'h0100);
        drain();

        // two keys forming one segment, opposite extremes in red, green and alpha
        reg_write(REG_KEY_COUNT, 64'd2);
        reg_write(REG_KEY_FIRST, key_word(16'h0100, 32'h00FF_8000));
        reg_write(REG_KEY_FIRST + 3'd1, key_word(16'h0000, 32'hFF00_80FF));
        send_age(16'h0000);
        send_age(16'h0001);
        send_age(16'h0080);
        send_age(16'h00FF);
        send_age(16'h0100);
        send_age(16'h0101);
        send_age(16'hFFFF);
        drain();

        // empty segments are skipped, longest duration
        reg_write(REG_KEY_COUNT, 64'd4);
        reg_write(REG_KEY_FIRST, key_word(16'h0000, 32'h1020_3040));
        reg_write(REG_KEY_FIRST + 3'd1, key_word(16'hFFFF, 32'hFFFF_FFFF));
        reg_write(REG_KEY_FIRST + 3'd2, key_word(16'h0000, 32'h0000_0000));
        reg_write(REG_KEY_FIRST + 3'd3, key_word(16'h0005, 32'hA5A5_5A5A));
        send_age(16'h0001);
        send_age(16'h8000);
        send_age(16'hFFFF);
        drain();

        // oversized key count saturates to four keys
        reg_write(REG_KEY_COUNT, 64'd7);
        for (int k = 0; k < NUM_KEYS; k++) begin
            reg_write(REG_KEY_FIRST + 3'(k), key_word(16'h0010, $urandom));
        end
        send_age(16'h0015);
        send_age(16'h0030);
        send_age(16'h0031);
        drain();

        // zero key count acts as one key
        reg_write(REG_KEY_COUNT, 64'd0);
        send_age(16'h1234);
        send_age(16'h0000);
        drain();

        // write beyond the last key register must be ignored
        reg_write(REG_KEY_COUNT, 64'd3);
        reg_write(REG_KEY_LAST + 3'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_age(16'h0018);
        send_age(16'h0025);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            random_setup();
            for (int i = 0; i < PHASE_AGES; i++) begin
                if (p != NUM_PHASES - 1 && $urandom_range(0, 3) == 0) begin
                    pause_sender($urandom_range(1, 5));
                end
                send_age(pick_age());
            end
            drain();
        end

        repeat (30) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed() == 0) begin
            $display("tb_colour_gradient_evaluator: PASS");
        end else begin
            $display("tb_colour_gradient_evaluator: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
sv/cge_pkg.sv
sv/cge_front.sv
sv/cge_queue.sv
sv/cge_back.sv
sv/colour_gradient_evaluator.sv
tb/tb_colour_gradient_evaluator.sv
